@@ rtl/knn_pkg.sv @@
// ---------------------------------------------------------------------------
// knn_pkg
// shared types and op codes for the knn classifier
// ---------------------------------------------------------------------------
`default_nettype none
package knn_pkg;
    typedef enum logic [1:0] {
        OP_TRAIN_FEAT = 2'd0,
        OP_TRAIN_LABEL = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    localparam int DIST_W = 40;
    localparam logic [1:0] REG_DIMS = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_K = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WAIT,
        ST_SEL,
        ST_VOTE,
        ST_OUT
    } t_state;

    // control from the top level to every cell
    typedef struct packed {
        logic acc;     // add the cell's registered square to its accumulator
        logic clr;     // clear accumulator
        logic shift;   // shift distance/label chain during selection
        logic load;    // load chain registers from accumulators
    } t_cell_ctl;
endpackage
`default_nettype wire

@@ rtl/knn_if.sv @@
// ---------------------------------------------------------------------------
// knn_req_if / knn_res_if
// valid/ready channels for requests and results
// ---------------------------------------------------------------------------
`default_nettype none
interface knn_req_if;
    logic valid;
    logic ready;
    logic [1:0] op;
    logic [3:0] row;
    logic [5:0] col;
    logic signed [15:0] value;
    logic [7:0] label;
    modport source (output valid, op, row, col, value, label, input ready);
    modport sink (input valid, op, row, col, value, label, output ready);
endinterface

interface knn_res_if;
    logic valid;
    logic ready;
    logic [7:0] winner;
    logic [3:0] votes;
    modport source (output valid, winner, votes, input ready);
    modport sink (input valid, winner, votes, output ready);
endinterface
`default_nettype wire

@@ rtl/knn_cell.sv @@
// ---------------------------------------------------------------------------
// knn_cell
// one training row: feature memory, squared distance accumulator, and a
// stage of the distance/label shift chain used by selection
// ---------------------------------------------------------------------------
`default_nettype none
module knn_cell #(
    parameter int DMAX = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_we,
    input  wire logic [((DMAX > 1) ? $clog2(DMAX) : 1)-1:0] i_waddr,
    input  wire logic [((DMAX > 1) ? $clog2(DMAX) : 1)-1:0] i_raddr,
    input  wire logic signed [15:0]                     i_wdata,
    input  wire logic                                   i_lwe,
    input  wire logic [7:0]                             i_label,
    input  wire logic signed [15:0]                     i_q,
    input  wire logic                                   i_in_use,
    input  wire knn_pkg::t_cell_ctl                     i_ctl,
    input  wire logic [knn_pkg::DIST_W-1:0]             i_chain_d,
    input  wire logic [7:0]                             i_chain_l,
    output logic [knn_pkg::DIST_W-1:0]                  o_chain_d,
    output logic [7:0]                                  o_chain_l
);
    localparam logic [knn_pkg::DIST_W-1:0] DMAXV = '1;

    logic signed [15:0] r_mem [DMAX];
    logic signed [15:0] r_feat;
    logic [7:0] r_label;
    logic [31:0] r_sq;
    logic [knn_pkg::DIST_W-1:0] r_acc, r_cd;
    logic [7:0] r_cl;
    logic signed [16:0] diff;
    logic [knn_pkg::DIST_W:0] sum;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_feat <= r_mem[i_raddr];
        if (i_lwe) r_label <= i_label;
    end

    assign diff = {r_feat[15], r_feat} - {i_q[15], i_q};
    assign sum = {1'b0, r_acc} + {9'd0, r_sq};

    always_ff @(posedge i_clk) begin
        r_sq <= 32'(diff * diff);
        if (!i_rst_n || i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc && i_in_use) begin
            r_acc <= sum[knn_pkg::DIST_W] ? DMAXV : sum[knn_pkg::DIST_W-1:0];
        end
        if (i_ctl.load) begin
            r_cd <= i_in_use ? r_acc : DMAXV;
            r_cl <= r_label;
        end else if (i_ctl.shift) begin
            r_cd <= i_chain_d;
            r_cl <= i_chain_l;
        end
    end

    assign o_chain_d = r_cd;
    assign o_chain_l = r_cl;
endmodule
`default_nettype wire

@@ rtl/knn_classifier.sv @@
// ---------------------------------------------------------------------------
// knn_classifier
// k nearest neighbors classifier, squared euclidean distance
// ---------------------------------------------------------------------------
// One cell per training row holds that row's features, its label and a
// 40-bit distance accumulator. Training writes and query features are taken
// one per cycle while idle; no request is taken until a result is accepted.
// Each query feature is read from every cell, squared and accumulated, in
// registered steps. On the query's last feature the block waits for the
// pipeline, then loads distances into the cell chain and shifts the whole
// chain once per neighbor, a running minimum at the chain's end picking the
// nearest unused row (ties to the lower row). Voting walks the k picks,
// counting for each how many of the picks share its label. There is no
// reset clearing pass; accumulators reset at once.
`default_nettype none
module knn_classifier #(
    parameter int NMAX = 16,
    parameter int DMAX = 64,
    parameter int KMAX = 8
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic [1:0] i_cfg_idx,
    input  wire logic [6:0] i_cfg_data,
    knn_req_if.sink    req,
    knn_res_if.source  res
);
    localparam int RW = (NMAX > 1) ? $clog2(NMAX) : 1;
    localparam int CW = $clog2(NMAX + 1);
    localparam int KW = $clog2(KMAX + 1);
    localparam int KIW = (KMAX > 1) ? $clog2(KMAX) : 1;
    localparam int DW = $clog2(DMAX + 1);
    localparam int AW = (DMAX > 1) ? $clog2(DMAX) : 1;
    localparam int DIST_W = knn_pkg::DIST_W;

    logic [6:0] r_dims;
    logic [4:0] r_rows;
    logic [3:0] r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims <= 7'd3;
            r_rows <= 5'd10;
            r_k <= 4'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                knn_pkg::REG_DIMS: r_dims <= i_cfg_data;
                knn_pkg::REG_ROWS: r_rows <= i_cfg_data[4:0];
                knn_pkg::REG_K: r_k <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective (clamped) configuration
    logic [DW-1:0] eff_d;
    logic [CW-1:0] eff_n;
    logic [KW-1:0] eff_k;
    always_comb begin
        if (r_dims == 7'd0) eff_d = DW'(1);
        else if (32'(r_dims) > DMAX) eff_d = DW'(DMAX);
        else eff_d = DW'(r_dims);
        if (r_rows == 5'd0) eff_n = CW'(1);
        else if (32'(r_rows) > NMAX) eff_n = CW'(NMAX);
        else eff_n = CW'(r_rows);
        if (r_k == 4'd0) eff_k = KW'(1);
        else if (32'(r_k) > KMAX) eff_k = KW'(KMAX);
        else eff_k = KW'(r_k);
        if (32'(eff_k) > 32'(eff_n)) eff_k = KW'(eff_n);
    end

    knn_pkg::t_state r_state, n_state;
    logic accept;
    assign req.ready = (r_state == knn_pkg::ST_IDLE);
    assign accept = req.valid && req.ready;

    logic is_train, is_lab, q_in, q_last;
    assign is_train = accept && req.op == knn_pkg::OP_TRAIN_FEAT &&
                      32'(req.col) < DMAX && 32'(req.row) < NMAX;
    assign is_lab = accept && req.op == knn_pkg::OP_TRAIN_LABEL && 32'(req.row) < NMAX;
    assign q_in = accept && req.op == knn_pkg::OP_QUERY && 7'(req.col) < 7'(eff_d);
    assign q_last = q_in && 7'(req.col) == 7'(eff_d) - 7'd1;

    // query pipeline: read (1), square (2), accumulate (3)
    logic [1:0] r_qv;
    logic signed [15:0] r_q1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_qv <= '0;
        else r_qv <= {r_qv[0], q_in};
        r_q1 <= req.value;
    end

    knn_pkg::t_cell_ctl ctl;
    logic [DIST_W-1:0] cd [NMAX+1];
    logic [7:0] cl [NMAX+1];
    assign cd[NMAX] = '1;
    assign cl[NMAX] = '0;

    for (genvar g = 0; g < NMAX; g++) begin : g_cell
        knn_cell #(.DMAX(DMAX)) u_cell (
            .i_clk(i_clk), .i_rst_n(i_rst_n),
            .i_we(is_train && 32'(req.row) == g),
            .i_waddr(AW'(req.col)), .i_raddr(AW'(req.col)),
            .i_wdata(req.value),
            .i_lwe(is_lab && 32'(req.row) == g), .i_label(req.label),
            .i_q(r_q1), .i_in_use(g < 32'(eff_n)), .i_ctl(ctl),
            .i_chain_d(cd[g+1]), .i_chain_l(cl[g+1]),
            .o_chain_d(cd[g]), .o_chain_l(cl[g])
        );
    end

    // selection: running minimum at the chain head, used rows masked
    logic [RW:0] r_pos;
    logic [KW-1:0] r_pick;
    logic [NMAX-1:0] r_used;
    logic r_found;
    logic [DIST_W-1:0] r_best_d;
    logic [RW-1:0] r_best_r;
    logic [7:0] r_best_l;
    logic [7:0] r_near [KMAX];
    logic [KW-1:0] r_i, r_j;
    logic [KW-1:0] r_cnt, r_win_cnt;
    logic [7:0] r_win_l;
    logic r_out_v;

    logic head_used, better;
    assign head_used = r_used[r_pos[RW-1:0]];
    assign better = !head_used && 32'(r_pos) < 32'(eff_n) &&
                    (!r_found || cd[0] < r_best_d);

    always_comb begin
        n_state = r_state;
        ctl = '0;
        ctl.acc = r_qv[1];
        unique case (r_state)
            knn_pkg::ST_IDLE: if (q_last) n_state = knn_pkg::ST_WAIT;
            knn_pkg::ST_WAIT: if (!r_qv[0] && !r_qv[1]) begin
                ctl.load = 1'b1;
                n_state = knn_pkg::ST_SEL;
            end
            knn_pkg::ST_SEL: begin
                ctl.shift = 1'b1;
                if (32'(r_pos) == NMAX - 1) begin
                    if (r_pick == eff_k - KW'(1)) begin
                        n_state = knn_pkg::ST_VOTE;
                        ctl.clr = 1'b1;
                    end else begin
                        ctl.shift = 1'b0;
                        ctl.load = 1'b1;
                    end
                end
            end
            knn_pkg::ST_VOTE:
                if (r_i == eff_k - KW'(1) && r_j == eff_k - KW'(1))
                    n_state = knn_pkg::ST_OUT;
            knn_pkg::ST_OUT: if (res.ready) n_state = knn_pkg::ST_IDLE;
            default: n_state = knn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= knn_pkg::ST_IDLE;
        else r_state <= n_state;
    end

    logic [KW-1:0] cnt_nx;
    assign cnt_nx = r_cnt + KW'(r_near[r_j[KIW-1:0]] == r_near[r_i[KIW-1:0]]);

    always_ff @(posedge i_clk) begin
        if (r_state == knn_pkg::ST_WAIT) begin
            r_pos <= '0; r_pick <= '0; r_used <= '0; r_found <= 1'b0;
            r_i <= '0; r_j <= '0; r_cnt <= '0; r_win_cnt <= '0; r_win_l <= '0;
        end else if (r_state == knn_pkg::ST_SEL) begin
            if (32'(r_pos) == NMAX - 1) begin
                // end of a pass: commit the pick, the head row included
                r_pos <= '0;
                r_found <= 1'b0;
                r_pick <= r_pick + KW'(1);
                r_used[better ? r_pos[RW-1:0] : r_best_r] <= 1'b1;
                r_near[r_pick[KIW-1:0]] <= better ? cl[0] : r_best_l;
            end else begin
                if (better) begin
                    r_found <= 1'b1; r_best_d <= cd[0];
                    r_best_r <= r_pos[RW-1:0]; r_best_l <= cl[0];
                end
                r_pos <= r_pos + (RW+1)'(1);
            end
        end else if (r_state == knn_pkg::ST_VOTE) begin
            if (r_j == eff_k - KW'(1)) begin
                r_j <= '0; r_cnt <= '0; r_i <= r_i + KW'(1);
                if (cnt_nx > r_win_cnt) begin
                    r_win_cnt <= cnt_nx; r_win_l <= r_near[r_i[KIW-1:0]];
                end
            end else begin
                r_j <= r_j + KW'(1); r_cnt <= cnt_nx;
            end
        end
    end

    always_comb r_out_v = (r_state == knn_pkg::ST_OUT);
    assign res.valid = r_out_v;
    assign res.winner = r_win_l;
    assign res.votes = 4'(r_win_cnt);
endmodule
`default_nettype wire

@@ rtl/knn_checker.sv @@
// ---------------------------------------------------------------------------
// knn_checker
// port level checks for the knn classifier
// ---------------------------------------------------------------------------
`default_nettype none
module knn_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic [7:0] res_winner,
    input wire logic [3:0] res_votes
);
    a_votes_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |-> res_votes != 4'd0) else $error("zero votes");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_winner))
        else $error("result dropped");
    a_no_take_during_result: assert property (@(posedge i_clk)
        disable iff (!i_rst_n) res_valid |-> !req_ready)
        else $error("request taken with pending result");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !res_valid) else $error("result after reset");
endmodule

bind knn_classifier knn_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(req.valid), .req_ready(req.ready),
    .res_valid(res.valid), .res_ready(res.ready),
    .res_winner(res.winner), .res_votes(res.votes)
);
`default_nettype wire

@@ tb/sv/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench for knn_classifier
// loads training rows, streams queries and checks each classification
// against a cycle-free predictor of the nearest-neighbor vote
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

class knn_scoreboard;
    typedef struct {
        logic [7:0] winner;
        logic [3:0] votes;
    } t_class_result;

    logic signed [15:0] feat [16][64];
    logic [7:0]         lab [16];
    logic [39:0]        acc_dist [16];
    int unsigned        dims_reg;
    int unsigned        rows_reg;
    int unsigned        k_reg;
    t_class_result      pending [$];
    int                 errors;
    int                 results;

    function new();
        dims_reg = 3;
        rows_reg = 10;
        k_reg    = 3;
        errors   = 0;
        results  = 0;
        foreach (acc_dist[r]) acc_dist[r] = '0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [6:0] data);
        if (idx == knn_pkg::REG_DIMS) dims_reg = 32'(data);
        else if (idx == knn_pkg::REG_ROWS) rows_reg = 32'(data[4:0]);
        else if (idx == knn_pkg::REG_K) k_reg = 32'(data[3:0]);
    endfunction

    // update stored state for one accepted request, predict its result
    function void note_request(knn_pkg::t_op op, logic [3:0] row, logic [5:0] col,
                               logic signed [15:0] value, logic [7:0] label);
        int unsigned d, n, k, best, cnt;
        longint diff;
        logic [63:0] acc;
        bit used [16];
        logic [7:0] near_lab [8];
        t_class_result res;
        case (op)
            knn_pkg::OP_TRAIN_FEAT: feat[row][col] = value;
            knn_pkg::OP_TRAIN_LABEL: lab[row] = label;
            knn_pkg::OP_QUERY: begin
                d = (dims_reg < 1) ? 1 : (dims_reg > 64) ? 64 : dims_reg;
                if (col > d - 1) return;
                n = (rows_reg < 1) ? 1 : (rows_reg > 16) ? 16 : rows_reg;
                for (int r = 0; r < n; r++) begin
                    diff = longint'(feat[r][col]) - longint'(value);
                    acc = {24'd0, acc_dist[r]} + 64'(diff * diff);
                    acc_dist[r] = (acc > 64'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : acc[39:0];
                end
                if (col != d - 1) return;
                k = (k_reg < 1) ? 1 : (k_reg > 8) ? 8 : k_reg;
                if (k > n) k = n;
                foreach (used[r]) used[r] = 0;
                for (int i = 0; i < k; i++) begin
                    best = 16;
                    for (int r = 0; r < n; r++)
                        if (!used[r] && (best == 16 || acc_dist[r] < acc_dist[best]))
                            best = r;
                    used[best] = 1;
                    near_lab[i] = lab[best];
                end
                res.winner = 0;
                res.votes  = 0;
                for (int i = 0; i < k; i++) begin
                    cnt = 0;
                    for (int j = 0; j < k; j++)
                        if (near_lab[j] == near_lab[i]) cnt++;
                    if (cnt > res.votes) begin
                        res.votes  = 4'(cnt);
                        res.winner = near_lab[i];
                    end
                end
                foreach (acc_dist[r]) acc_dist[r] = '0;
                pending.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function void check_result(logic [7:0] winner, logic [3:0] votes);
        t_class_result exp_res;
        results++;
        if (pending.size() == 0) begin
            $error("unexpected result winner=%0d votes=%0d", winner, votes);
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        if (winner !== exp_res.winner) begin
            $error("winner: expected %0d, actual %0d", exp_res.winner, winner);
            errors++;
        end
        if (votes !== exp_res.votes) begin
            $error("votes: expected %0d, actual %0d", exp_res.votes, votes);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int SETTLE_CYCLES = 260;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [6:0] i_cfg_data;

    knn_req_if req ();
    knn_res_if res ();

    knn_classifier uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .req        (req.sink),
        .res        (res.source)
    );

    knn_scoreboard sb;
    bit quiet;            // no idling on either side
    bit hold_req;         // asks the receiver for a long hold-off
    int stall_cnt;
    int requests_sent;
    int queries_done;
    bit feat_ok [16][64]; // written entries, so no unwritten read is caused
    bit lab_ok [16];
    int eff_d, eff_n;

    initial i_clk = 0;
    always #5 i_clk = ~i_clk;

    // receiver: check results, random ready, long hold-off on request
    int hold_left;
    always @(posedge i_clk) begin
        if (res.valid && res.ready) begin
            sb.check_result(res.winner, res.votes);
            stall_cnt <= 0;
        end else if (req.valid && req.ready) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            res.ready <= 1'b0;
        end else begin
            res.ready <= quiet || ($urandom_range(99) >= 31);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if (stall_cnt >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cnt);
            $display("FAIL");
            $finish;
        end
    end

    // one request, held until accepted; random gaps before it
    task automatic send(knn_pkg::t_op op, logic [3:0] row, logic [5:0] col,
                        logic signed [15:0] value, logic [7:0] label);
        while (!quiet && $urandom_range(99) < 31) begin
            req.valid <= 1'b0;
            @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.op    <= op;
        req.row   <= row;
        req.col   <= col;
        req.value <= value;
        req.label <= label;
        do @(posedge i_clk); while (!req.ready);
        sb.note_request(op, row, col, value, label);
        if (op == knn_pkg::OP_TRAIN_FEAT) feat_ok[row][col] = 1;
        if (op == knn_pkg::OP_TRAIN_LABEL) lab_ok[row] = 1;
        if (op != knn_pkg::OP_NONE && !(op == knn_pkg::OP_QUERY && col > eff_d - 1))
            requests_sent++;
    endtask

    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            1: return 16'($signed($urandom_range(8)) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // labels from a few classes so votes collide and tie
    function automatic logic [7:0] pick_label();
        return $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(3));
    endfunction

    // config only while idle: drain results, let the pipeline settle
    task automatic write_cfg(logic [1:0] idx, logic [6:0] data);
        req.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(logic [6:0] d, logic [4:0] n, logic [3:0] k);
        write_cfg(knn_pkg::REG_DIMS, d);
        write_cfg(knn_pkg::REG_ROWS, 7'(n));
        write_cfg(knn_pkg::REG_K, 7'(k));
        eff_d = (d < 1) ? 1 : (d > 64) ? 64 : d;
        eff_n = (n < 1) ? 1 : (n > 16) ? 16 : n;
    endtask

    // make sure every row in use has a label and all features a query reads
    task automatic fill_rows();
        for (int r = 0; r < eff_n; r++) begin
            if (!lab_ok[r]) send(knn_pkg::OP_TRAIN_LABEL, 4'(r), 6'($urandom),
                                 16'($urandom), pick_label());
            for (int c = 0; c < eff_d; c++)
                if (!feat_ok[r][c]) send(knn_pkg::OP_TRAIN_FEAT, 4'(r), 6'(c),
                                         pick_value(), 8'($urandom));
        end
    endtask

    task automatic run_query();
        for (int c = 0; c < eff_d; c++)
            send(knn_pkg::OP_QUERY, 4'($urandom), 6'(c), pick_value(), 8'($urandom));
        queries_done++;
    endtask

    initial begin
        logic [6:0] d;
        logic [4:0] n;
        int phase;
        sb = new();
        req.valid  = 0;
        req.op     = knn_pkg::OP_NONE;
        req.row    = 0;
        req.col    = 0;
        req.value  = 0;
        req.label  = 0;
        res.ready  = 0;
        i_cfg_we   = 0;
        i_cfg_idx  = knn_pkg::REG_DIMS;
        i_cfg_data = 0;
        i_rst_n    = 0;
        stall_cnt  = 0;
        hold_left  = 0;
        quiet = 0;
        hold_req = 0;
        requests_sent = 0;
        queries_done = 0;
        eff_d = 3;
        eff_n = 10;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: equal distances tie toward the lower row, a 2:2 vote
        // tie goes to the nearer neighbor, extreme values give the
        // largest square
        configure(7'd2, 5'd4, 4'd4);
        for (int r = 0; r < 4; r++) begin
            send(knn_pkg::OP_TRAIN_LABEL, 4'(r), 6'd0, 16'sd0, (r % 2) ? 8'd2 : 8'd1);
            send(knn_pkg::OP_TRAIN_FEAT, 4'(r), 6'd0, 16'sh8000, 8'd0);
            send(knn_pkg::OP_TRAIN_FEAT, 4'(r), 6'd1, 16'sh8000, 8'd0);
        end
        send(knn_pkg::OP_NONE, 4'd15, 6'd63, 16'sh7FFF, 8'hFF);   // ignored op
        send(knn_pkg::OP_QUERY, 4'd0, 6'd5, 16'sd7, 8'd0);        // col beyond dims
        send(knn_pkg::OP_QUERY, 4'd0, 6'd0, 16'sh7FFF, 8'd0);
        send(knn_pkg::OP_QUERY, 4'd0, 6'd1, 16'sh7FFF, 8'd0);
        send(knn_pkg::OP_TRAIN_LABEL, 4'd15, 6'd0, 16'sd0, 8'hFF);
        send(knn_pkg::OP_TRAIN_FEAT, 4'd2, 6'd1, 16'sd0, 8'd0);   // row 2 now nearest
        send(knn_pkg::OP_QUERY, 4'd0, 6'd0, 16'sh7FFF, 8'd0);
        send(knn_pkg::OP_QUERY, 4'd0, 6'd1, 16'sd0, 8'd0);

        // register extremes, clamped ones included
        configure(7'd64, 5'd1, 4'd8);
        fill_rows();
        run_query();
        configure(7'd0, 5'd31, 4'd0);
        fill_rows();
        run_query();
        configure(7'd127, 5'd0, 4'd15);
        fill_rows();
        run_query();

        phase = 0;
        while (requests_sent < 1300) begin
            phase++;
            if ($urandom_range(5) == 0) begin
                d = $urandom_range(1) ? 7'd64 : 7'($urandom_range(127, 65));
                n = 5'($urandom_range(2));
            end else begin
                d = 7'($urandom_range(8));
                n = $urandom_range(7) == 0 ? 5'($urandom_range(31, 16)) : 5'($urandom_range(16));
            end
            configure(d, n, 4'($urandom));
            quiet = (phase >= 4 && phase <= 6);
            if (phase == 3) hold_req = 1;
            fill_rows();
            for (int i = 0; i < 12; i++) begin
                if (requests_sent >= 1300) break;
                case ($urandom_range(9))
                    0: send(knn_pkg::OP_NONE, 4'($urandom), 6'($urandom), 16'($urandom),
                            8'($urandom));
                    1: send(knn_pkg::OP_QUERY, 4'($urandom),
                            eff_d < 64 ? 6'($urandom_range(63, eff_d)) : 6'($urandom),
                            pick_value(), 8'($urandom));
                    2: send(knn_pkg::OP_TRAIN_FEAT, 4'($urandom), 6'($urandom), pick_value(),
                            8'($urandom));
                    3: send(knn_pkg::OP_TRAIN_LABEL, 4'($urandom), 6'($urandom), 16'($urandom),
                            pick_label());
                    default: begin
                        fill_rows();
                        run_query();
                    end
                endcase
            end
        end
        quiet = 0;

        req.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("covered %0d requests, %0d queries, %0d results over %0d phases",
                 requests_sent, queries_done, sb.results, phase);
        $display("register extremes, ignored ops, distance and vote ties, stalls");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
rtl/knn_pkg.sv
rtl/knn_if.sv
rtl/knn_cell.sv
rtl/knn_classifier.sv
rtl/knn_checker.sv
tb/sv/testbench.sv
